FILE: hdl/acss_pkg.sv
// Shared types, constants and helpers for the ADC channel scan sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package acss_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_SLOT_W    = 4;
    localparam int TABLE_SLOTS   = 8;
    localparam int SLOT_BITS     = 5;
    localparam int TABLE_W       = TABLE_SLOTS * SLOT_BITS;
    localparam int SAMPLE_W      = 10;
    localparam int CHAN_W        = 4;
    localparam int REF_W         = 2;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 24;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CHANNELS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_CHANNELS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_SELECT = 2'd2;

    localparam logic [TABLE_W-1:0] SLOT_TABLE_RESET = {TABLE_W{1'b1}};
    localparam logic [REF_W-1:0]   REFERENCE_RESET  = 2'd1;
    localparam logic [SLOT_BITS-1:0] UNUSED_ENTRY   = 5'h10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                  any_used;
        logic [MAX_SLOT_W-1:0] next_slot;
        logic [CHAN_W-1:0]     next_channel;
    } scan_t;

    function automatic logic [SLOT_BITS-1:0] slot_entry(
        input logic [TABLE_W-1:0]    tbl,
        input logic [MAX_SLOT_W-1:0] s
    );
        logic [SLOT_BITS-1:0] e;
        e = UNUSED_ENTRY;
        if (s < MAX_SLOT_W'(TABLE_SLOTS))
            e = tbl[SLOT_BITS * int'(s) +: SLOT_BITS];
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/acss_result_mem.sv
// Result store: one sample per slot, one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
`default_nettype none

module acss_result_mem
    import acss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEFAULT,
    parameter int SLOT_W = MAX_SLOT_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [SLOT_W-1:0]   wr_addr,
    input  wire logic [SAMPLE_W-1:0] wr_data,
    input  wire logic                rd_en,
    input  wire logic [SLOT_W-1:0]   rd_addr,
    output logic      [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]    valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/acss_slot_scan.sv
// Next-used-slot search: priority pick of the nearest used slot after the
// current one, with wrap. Depends on acss_pkg.
`default_nettype none

module acss_slot_scan
    import acss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEFAULT,
    parameter int SLOT_W = MAX_SLOT_W
) (
    input  wire logic [TABLE_W-1:0] slot_table,
    input  wire logic [SLOT_W-1:0]  cur_slot,
    output scan_t                   scan
);

    always_comb
    begin
        logic [MAX_SLOT_W:0]    cand;
        logic [SLOT_BITS-1:0]   e;
        scan = '0;
        for (int k = SLOTS; k >= 1; k--)
        begin
            cand = (MAX_SLOT_W+1)'(cur_slot) + (MAX_SLOT_W+1)'(k);
            if (cand >= (MAX_SLOT_W+1)'(SLOTS))
                cand = cand - (MAX_SLOT_W+1)'(SLOTS);
            e = slot_entry(slot_table, cand[MAX_SLOT_W-1:0]);
            if (!e[SLOT_BITS-1])
            begin
                scan.any_used     = 1'b1;
                scan.next_slot    = cand[MAX_SLOT_W-1:0];
                scan.next_channel = e[CHAN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/adc_channel_scan_sequencer.sv
// ADC channel scan sequencer, top level. Uses acss_pkg, acss_result_mem, acss_slot_scan.
// Start and done words give their result word in the cycle after accept;
// reads of a valid slot pass first through the result store's registered read port and the ST_READ state.
// One word in flight: input is held off during a valid read and while the result word is stalled.
// Reset (async, active low) returns config to its reset values and clears scan position,
// channel and all store valid bits.
`default_nettype none

module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEFAULT,
    parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // sample[9:0], slot_index[13:10], zero
    input  wire logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // start_conversion[0], mux_channel[4:1],
                                                  // reference_bits[6:5], read_data[16:7],
                                                  // read_ok[17], zero
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [TABLE_W-1:0]    cfg_data
);

    logic [TABLE_W-1:0]  slot_table_reg;
    logic                wide_reg;
    logic [REF_W-1:0]    ref_reg;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic                ov_reg, ov_next;
    logic                start_reg, start_next;
    logic [SAMPLE_W-1:0] rdata_reg, rdata_next;
    logic                rok_reg, rok_next;

    logic [FUNC_W-1:0]     func;
    logic [SAMPLE_W-1:0]   sample;
    logic [MAX_SLOT_W-1:0] slot_index;
    logic [SLOT_BITS-1:0]  rd_entry;
    logic                  rd_ok;
    logic                  accept;
    logic                  wr_en;
    logic                  rd_en;
    logic [SAMPLE_W-1:0]   mem_rd_data;
    scan_t                 scan;

    assign func       = s_tuser;
    assign sample     = s_tdata[SAMPLE_W-1:0];
    assign slot_index = s_tdata[SAMPLE_W +: MAX_SLOT_W];
    assign rd_entry   = slot_entry(slot_table_reg, slot_index);
    assign rd_ok      = ((MAX_SLOT_W+1)'(slot_index) < (MAX_SLOT_W+1)'(SLOTS))
                        && !rd_entry[SLOT_BITS-1]
                        && (wide_reg || !rd_entry[CHAN_W-1]);

    assign s_tready = (state_reg == ST_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (func == FUNC_DONE) && scan.any_used;
    assign rd_en    = accept && (func == FUNC_READ) && rd_ok;

    acss_slot_scan #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_scan (
        .slot_table (slot_table_reg),
        .cur_slot   (cur_slot_reg),
        .scan       (scan)
    );

    acss_result_mem #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (cur_slot_reg),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (slot_index[SLOT_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_table_reg <= SLOT_TABLE_RESET;
            wide_reg       <= 1'b0;
            ref_reg        <= REFERENCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLOT_CHANNELS:    slot_table_reg <= cfg_data;
                CFG_WIDE_CHANNELS:    wide_reg       <= cfg_data[0];
                CFG_REFERENCE_SELECT: ref_reg        <= cfg_data[REF_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_slot_reg <= '0;
            chan_reg     <= '0;
            ov_reg       <= 1'b0;
            start_reg    <= 1'b0;
            rdata_reg    <= '0;
            rok_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_slot_reg <= cur_slot_next;
            chan_reg     <= chan_next;
            ov_reg       <= ov_next;
            start_reg    <= start_next;
            rdata_reg    <= rdata_next;
            rok_reg      <= rok_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_slot_next = cur_slot_reg;
        chan_next     = chan_reg;
        ov_next       = ov_reg && !m_tready;
        start_next    = start_reg;
        rdata_next    = rdata_reg;
        rok_next      = rok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    start_next = 1'b0;
                    rdata_next = '0;
                    rok_next   = 1'b0;
                    ov_next    = 1'b1;
                    priority if (func == FUNC_START)
                        start_next = 1'b1;
                    else if (func == FUNC_DONE)
                    begin
                        if (scan.any_used)
                        begin
                            cur_slot_next = scan.next_slot[SLOT_W-1:0];
                            chan_next     = scan.next_channel;
                            start_next    = (scan.next_slot != '0);
                        end
                    end
                    else if (func == FUNC_READ)
                    begin
                        if (rd_ok)
                        begin
                            ov_next    = 1'b0;
                            state_next = ST_READ;
                        end
                    end
                    else
                        start_next = 1'b0;
                end
            end
            ST_READ:
            begin
                ov_next    = 1'b1;
                rdata_next = mem_rd_data;
                rok_next   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'b0, rok_reg, rdata_reg, ref_reg, chan_reg, start_reg};

endmodule

`default_nettype wire

FILE: hdl/acss_checker.sv
// Port-level checks for the ADC channel scan sequencer, bound to the top level.
// Depends on acss_pkg and adc_channel_scan_sequencer.
`default_nettype none

module acss_checker
    import acss_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    a_no_word_after_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output word right after reset");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_no_accept_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result blocked");

    a_read_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[17] |-> m_tdata[16:7] == '0)
        else $error("read data without read ok");

    a_start_not_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[17]))
        else $error("start and read ok together");

endmodule

bind adc_channel_scan_sequencer acss_checker u_acss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/adc_channel_scan_sequencer_tb.sv
// Self-checking testbench for the ADC channel scan sequencer.
// Drives command words and register writes, predicts each status word in a
// scoreboard class. Depends on acss_pkg and adc_channel_scan_sequencer.
`default_nettype none

module adc_channel_scan_sequencer_tb;
    import acss_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                read_ok;
        logic [SAMPLE_W-1:0] read_data;
        logic [REF_W-1:0]    reference_bits;
        logic [CHAN_W-1:0]   mux_channel;
        logic                start_conversion;
    } scan_status_t;

    class scan_scoreboard;
        logic [TABLE_W-1:0]  slot_table;
        logic                wide_mode;
        logic [REF_W-1:0]    ref_code;
        logic [SAMPLE_W-1:0] samples [TABLE_SLOTS];
        int unsigned         scan_slot;
        logic [CHAN_W-1:0]   mux_now;
        scan_status_t        expected_status [$];
        int                  fail_count;
        int                  word_count;
        int                  func_count [4];
        int                  setting_count;

        function new();
            slot_table = SLOT_TABLE_RESET;
            wide_mode  = 1'b0;
            ref_code   = REFERENCE_RESET;
            foreach (samples[i])
                samples[i] = '0;
            scan_slot  = 0;
            mux_now    = '0;
            fail_count = 0;
            word_count = 0;
            setting_count = 0;
            foreach (func_count[i])
                func_count[i] = 0;
        endfunction

        function logic [SLOT_BITS-1:0] table_entry(int unsigned s);
            if (s >= TABLE_SLOTS)
                return UNUSED_ENTRY;
            return slot_table[s*SLOT_BITS +: SLOT_BITS];
        endfunction

        function bit slot_in_use(int unsigned s);
            logic [SLOT_BITS-1:0] e;
            e = table_entry(s);
            return e[SLOT_BITS-1] == 1'b0;
        endfunction

        function void set_registers(logic [TABLE_W-1:0] tbl, logic wide, logic [REF_W-1:0] rc);
            slot_table = tbl;
            wide_mode  = wide;
            ref_code   = rc;
            setting_count++;
        endfunction

        function void accept_command(logic [FUNC_W-1:0] func, logic [SAMPLE_W-1:0] sample,
                                     logic [3:0] slot);
            scan_status_t want;
            int unsigned  s;
            bit           found;
            logic [CHAN_W-1:0] ch;
            logic [SLOT_BITS-1:0] e;
            want = '0;
            found = 1'b0;
            func_count[func]++;
            case (func)
                FUNC_START:
                    want.start_conversion = 1'b1;
                FUNC_DONE:
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (slot_in_use(i))
                            found = 1'b1;
                    if (found)
                    begin
                        samples[scan_slot] = sample;
                        s = scan_slot;
                        for (int k = 1; k <= TABLE_SLOTS; k++)
                        begin
                            s = (scan_slot + k) % TABLE_SLOTS;
                            if (slot_in_use(s))
                                break;
                        end
                        scan_slot = s;
                        e = table_entry(s);
                        mux_now = e[CHAN_W-1:0];
                        want.start_conversion = (s != 0);
                    end
                end
                FUNC_READ:
                begin
                    if (slot < TABLE_SLOTS && slot_in_use(slot))
                    begin
                        e = table_entry(slot);
                        ch = e[CHAN_W-1:0];
                        if (wide_mode || ch < 8)
                        begin
                            want.read_data = samples[slot];
                            want.read_ok   = 1'b1;
                        end
                    end
                end
                default:
                    ;
            endcase
            want.mux_channel    = mux_now;
            want.reference_bits = ref_code;
            expected_status.push_back(want);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_status(logic [OUT_DATA_W-1:0] word);
            scan_status_t got, want;
            got = word[$bits(scan_status_t)-1:0];
            word_count++;
            if (expected_status.size() == 0)
            begin
                $error("status word 0x%0h with nothing expected", word);
                fail_count++;
                return;
            end
            want = expected_status.pop_front();
            check_field("start_conversion", want.start_conversion, got.start_conversion);
            check_field("mux_channel", want.mux_channel, got.mux_channel);
            check_field("reference_bits", want.reference_bits, got.reference_bits);
            check_field("read_data", want.read_data, got.read_data);
            check_field("read_ok", want.read_ok, got.read_ok);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TABLE_W-1:0]    cfg_data  = '0;

    bit steady = 1'b0;
    scan_scoreboard sb = new();

    adc_channel_scan_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_status(m_tdata);
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 17);
    end

    initial
    begin
        #400000;
        $display("adc_channel_scan_sequencer_tb: FAIL");
        $finish;
    end

    task automatic send_command(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] sample,
                                input logic [3:0] slot);
        while (!steady && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, slot, sample};
        do
            @(posedge clk);
        while (!s_tready);
        sb.accept_command(func, sample, slot);
    endtask

    // hold off input until every status word is back
    task automatic drain_status();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [TABLE_W-1:0] tbl, input logic wide,
                                  input logic [REF_W-1:0] rc);
        drain_status();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLOT_CHANNELS;
        cfg_data  <= tbl;
        @(posedge clk);
        cfg_index <= CFG_WIDE_CHANNELS;
        cfg_data  <= TABLE_W'(wide);
        @(posedge clk);
        cfg_index <= CFG_REFERENCE_SELECT;
        cfg_data  <= TABLE_W'(rc);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_registers(tbl, wide, rc);
    endtask

    function automatic logic [TABLE_W-1:0] random_table(int unused_pct, bit low_channels);
        logic [TABLE_W-1:0] tbl;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            if ($urandom_range(99) < unused_pct)
                tbl[s*SLOT_BITS +: SLOT_BITS] = {1'b1, 4'($urandom_range(15))};
            else if (low_channels)
                tbl[s*SLOT_BITS +: SLOT_BITS] = {1'b0, 4'($urandom_range(7))};
            else
                tbl[s*SLOT_BITS +: SLOT_BITS] = {1'b0, 4'($urandom_range(15))};
        end
        return tbl;
    endfunction

    function automatic logic [TABLE_W-1:0] one_slot_table(int s, logic [CHAN_W-1:0] ch);
        logic [TABLE_W-1:0] tbl;
        tbl = SLOT_TABLE_RESET;
        tbl[s*SLOT_BITS +: SLOT_BITS] = {1'b0, ch};
        return tbl;
    endfunction

    task automatic random_command();
        int unsigned       pick;
        logic [FUNC_W-1:0] func;
        logic [SAMPLE_W-1:0] sample;
        logic [3:0]        slot;
        pick = $urandom_range(99);
        if (pick < 10)
            func = FUNC_START;
        else if (pick < 55)
            func = FUNC_DONE;
        else if (pick < 95)
            func = FUNC_READ;
        else
            func = FUNC_UNKNOWN;
        pick = $urandom_range(99);
        if (pick < 8)
            sample = '0;
        else if (pick < 16)
            sample = '1;
        else
            sample = SAMPLE_W'($urandom_range(1023));
        if ($urandom_range(99) < 80)
            slot = 4'($urandom_range(7));
        else
            slot = 4'($urandom_range(15, 8));
        send_command(func, sample, slot);
    endtask

    initial
    begin
        logic [TABLE_W-1:0] tbl;
        logic               wide;
        logic [REF_W-1:0]   rc;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table has no used slot
        send_command(FUNC_UNKNOWN, 10'h3FF, 4'hF);
        send_command(FUNC_START, 10'h000, 4'h0);
        send_command(FUNC_DONE, 10'h3FF, 4'h0);
        send_command(FUNC_READ, 10'h000, 4'h0);
        send_command(FUNC_READ, 10'h3FF, 4'hF);

        // slots: 0 ch0, 1 unused, 2 ch15, 3 ch7, 4 ch8, rest unused
        tbl = {5'h1F, 5'h1F, 5'h1F, 5'h08, 5'h07, 5'h0F, 5'h1A, 5'h00};
        apply_settings(tbl, 1'b0, 2'd3);
        send_command(FUNC_DONE, 10'h3FF, 4'h0);
        send_command(FUNC_DONE, 10'h000, 4'h0);
        send_command(FUNC_DONE, 10'h2AA, 4'h0);
        send_command(FUNC_DONE, 10'h155, 4'h0);
        send_command(FUNC_READ, 10'h000, 4'd0);
        send_command(FUNC_READ, 10'h000, 4'd2);
        send_command(FUNC_READ, 10'h000, 4'd3);
        send_command(FUNC_READ, 10'h000, 4'd4);
        send_command(FUNC_READ, 10'h000, 4'd1);
        send_command(FUNC_READ, 10'h000, 4'd8);
        send_command(FUNC_READ, 10'h000, 4'd15);
        send_command(FUNC_START, 10'h3FF, 4'hF);

        apply_settings(tbl, 1'b1, 2'd0);
        send_command(FUNC_READ, 10'h000, 4'd2);
        send_command(FUNC_READ, 10'h000, 4'd4);

        // drop slot 0 from the table while the scan sits on it
        tbl = one_slot_table(5, 4'd9);
        apply_settings(tbl, 1'b1, 2'd2);
        send_command(FUNC_DONE, 10'h1C3, 4'h0);
        send_command(FUNC_READ, 10'h000, 4'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            wide = 1'($urandom_range(1));
            rc   = REF_W'($urandom_range(3));
            case (phase)
                0:
                begin
                    tbl  = '0;
                    wide = 1'b0;
                    rc   = 2'd0;
                end
                1: tbl = one_slot_table(0, 4'd5);
                2:
                begin
                    tbl  = one_slot_table(7, 4'd12);
                    wide = 1'b1;
                end
                3:
                begin
                    tbl = SLOT_TABLE_RESET;
                    rc  = 2'd3;
                end
                5: tbl = random_table(70, 1'b0);
                7:
                begin
                    tbl  = random_table(30, 1'b0);
                    wide = 1'b1;
                    rc   = 2'd3;
                end
                default: tbl = random_table(30, phase[0]);
            endcase
            apply_settings(tbl, wide, rc);
            steady = (phase == 4);
            repeat (85) random_command();
        end
        steady = 1'b0;

        drain_status();
        repeat (10) @(posedge clk);

        $display("covered %0d status words: %0d start, %0d done, %0d read, %0d unknown",
                 sb.word_count, sb.func_count[FUNC_START], sb.func_count[FUNC_DONE],
                 sb.func_count[FUNC_READ], sb.func_count[FUNC_UNKNOWN]);
        $display("across %0d register settings with random stalls on both sides",
                 sb.setting_count);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("adc_channel_scan_sequencer_tb: PASS");
        else
            $display("adc_channel_scan_sequencer_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
